[rtl/tcw_pkg.sv]
// Shared constants, payload types and controller/datapath interface types for the text console.
package tcw_pkg;

   localparam int unsigned MAX_LINES   = 64;
   localparam int unsigned COLUMNS     = 80;
   localparam int unsigned SCREEN_ROWS = 25;
   localparam int unsigned STORE_CELLS = MAX_LINES * COLUMNS;

   localparam int unsigned ADDR_W  = 13;
   localparam int unsigned COL_W   = $clog2(COLUMNS);
   localparam int unsigned STEP_W  = $clog2(COLUMNS + 1);
   localparam int unsigned LINES_W = 7;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned ATTR_W  = 8;
   localparam int unsigned CELL_W  = CHAR_W + ATTR_W;
   localparam int unsigned CSR_W   = 8;

   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [ATTR_W-1:0] PLAIN_ATTR = 8'd7;

   localparam logic [CELL_W-1:0] BLANK_CELL = {PLAIN_ATTR, 8'h00};
   localparam logic [CELL_W-1:0] SPACE_CELL = {PLAIN_ATTR, CH_SPACE};

   localparam logic [ATTR_W-1:0]  RESET_ATTR  = 8'd7;
   localparam logic [LINES_W-1:0] RESET_LINES = 7'd64;

   typedef enum logic [0:0] {
      OP_PUT  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_TEXT_ATTR    = 1'b0,
      CSR_REGION_LINES = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [0:0]        opcode;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cursor_pos;
      logic [ADDR_W-1:0] view_start;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_LOAD,
      DP_PRINT,
      DP_NL_FILL,
      DP_BS_READ,
      DP_BS_STEP,
      DP_BS_SPACE,
      DP_SCROLL_START,
      DP_SCROLL_COPY,
      DP_SCROLL_ZERO,
      DP_VIEW,
      DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      logic clear_last;
      logic is_read;
      logic is_nl;
      logic is_bs;
      logic cur_zero;
      logic nl_last;
      logic bs_blank;
      logic bs_moved;
      logic bs_stop;
      logic scroll_need;
      logic copy_done;
      logic zero_last;
      logic rsp_free;
   } dp_status_type;

endpackage

[rtl/tcw_cell_ram.sv]
// Cell store: one write port and one registered read port.
module tcw_cell_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [tcw_pkg::ADDR_W-1:0]        wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]        wr_data,
   input  logic [tcw_pkg::ADDR_W-1:0]        rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]        rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::STORE_CELLS];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_addr < tcw_pkg::ADDR_W'(tcw_pkg::STORE_CELLS)) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tcw_datapath.sv]
// Datapath: cursor, view, configuration, walk pointer, cell store access and result register.
module tcw_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tcw_pkg::dp_op_type              cmd,
   output tcw_pkg::dp_status_type          status,
   input  tcw_pkg::req_type                req_data,
   output tcw_pkg::rsp_type                rsp_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [tcw_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int unsigned AW = tcw_pkg::ADDR_W;
   localparam int unsigned CW = tcw_pkg::COL_W;
   localparam int unsigned SW = tcw_pkg::STEP_W;
   localparam int unsigned LW = tcw_pkg::LINES_W;

   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] view_ff, view_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic          pend_ff, pend_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [tcw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic [LW-1:0] region_ff, region_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_ff, rsp_in;
   tcw_pkg::req_type item_ff, item_in;

   logic [LW-1:0] lines;
   logic [AW-1:0] limit;
   logic [AW-1:0] last;
   logic [AW:0]   view_end;
   logic [AW-1:0] cursor_dec;
   logic [CW-1:0] col_inc;
   logic [CW-1:0] col_dec;
   logic          idx_ok;

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
   logic [AW-1:0]               mem_raddr;
   logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

   tcw_cell_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Region size: saturate at the store depth, treat zero as one line
   always_comb begin
      if (region_ff == '0) begin
         lines = LW'(1);
      end else if (region_ff > LW'(tcw_pkg::MAX_LINES)) begin
         lines = LW'(tcw_pkg::MAX_LINES);
      end else begin
         lines = region_ff;
      end
   end

   assign limit      = AW'(32'(lines) * tcw_pkg::COLUMNS);
   assign last       = limit - AW'(tcw_pkg::COLUMNS);
   assign view_end   = {1'b0, view_ff} + (AW + 1)'(tcw_pkg::SCREEN_ROWS * tcw_pkg::COLUMNS);
   assign cursor_dec = cursor_ff - AW'(1);
   assign col_inc    = (col_ff == CW'(tcw_pkg::COLUMNS - 1)) ? '0 : col_ff + CW'(1);
   assign col_dec    = (col_ff == '0) ? CW'(tcw_pkg::COLUMNS - 1) : col_ff - CW'(1);
   assign idx_ok     = item_ff.cell_index < AW'(tcw_pkg::STORE_CELLS);

   always_comb begin
      status.clear_last  = ptr_ff == AW'(tcw_pkg::STORE_CELLS - 1);
      status.is_read     = item_ff.opcode == tcw_pkg::OP_READ;
      status.is_nl       = (item_ff.char_code == tcw_pkg::CH_LF) ||
                           (item_ff.char_code == tcw_pkg::CH_CR);
      status.is_bs       = item_ff.char_code == tcw_pkg::CH_BS;
      status.cur_zero    = cursor_ff == '0;
      status.nl_last     = col_ff == CW'(tcw_pkg::COLUMNS - 1);
      status.bs_blank    = mem_rdata == tcw_pkg::BLANK_CELL;
      status.bs_moved    = steps_ff != '0;
      status.bs_stop     = (cursor_ff == AW'(1)) || (steps_ff == SW'(tcw_pkg::COLUMNS - 1));
      status.scroll_need = cursor_ff >= limit;
      status.copy_done   = (ptr_ff == last) && !pend_ff;
      status.zero_last   = ptr_ff == limit - AW'(1);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cursor_in    = cursor_ff;
      col_in       = col_ff;
      view_in      = view_ff;
      ptr_in       = ptr_ff;
      wr_addr_in   = wr_addr_ff;
      pend_in      = pend_ff;
      steps_in     = steps_ff;
      attr_in      = attr_ff;
      region_in    = region_ff;
      rsp_in       = rsp_ff;
      item_in      = item_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = cursor_ff;
      mem_wdata    = '0;
      mem_raddr    = item_ff.cell_index;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (tcw_pkg::csr_reg_type'(csr_index))
            tcw_pkg::CSR_TEXT_ATTR:    attr_in   = csr_wdata[tcw_pkg::ATTR_W-1:0];
            tcw_pkg::CSR_REGION_LINES: region_in = csr_wdata[LW-1:0];
            default: ;
         endcase
      end

      unique case (cmd)
         tcw_pkg::DP_NOP: ;
         tcw_pkg::DP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            ptr_in    = ptr_ff + AW'(1);
         end
         tcw_pkg::DP_LOAD: begin
            item_in  = req_data;
            steps_in = '0;
         end
         tcw_pkg::DP_PRINT: begin
            mem_we    = 1'b1;
            mem_wdata = {attr_ff, item_ff.char_code};
            cursor_in = cursor_ff + AW'(1);
            col_in    = col_inc;
         end
         tcw_pkg::DP_NL_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = tcw_pkg::BLANK_CELL;
            cursor_in = cursor_ff + AW'(1);
            col_in    = col_inc;
         end
         tcw_pkg::DP_BS_READ: begin
            mem_raddr = cursor_dec;
         end
         tcw_pkg::DP_BS_STEP: begin
            cursor_in = cursor_dec;
            col_in    = col_dec;
            steps_in  = steps_ff + SW'(1);
         end
         tcw_pkg::DP_BS_SPACE: begin
            mem_we    = 1'b1;
            mem_waddr = cursor_dec;
            mem_wdata = tcw_pkg::SPACE_CELL;
            cursor_in = cursor_dec;
            col_in    = col_dec;
         end
         tcw_pkg::DP_SCROLL_START: begin
            ptr_in  = '0;
            pend_in = 1'b0;
         end
         tcw_pkg::DP_SCROLL_COPY: begin
            // write the cell fetched last cycle while fetching the next one
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = mem_rdata;
            end
            if (ptr_ff < last) begin
               mem_raddr  = ptr_ff + AW'(tcw_pkg::COLUMNS);
               wr_addr_in = ptr_ff;
               pend_in    = 1'b1;
               ptr_in     = ptr_ff + AW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         tcw_pkg::DP_SCROLL_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            ptr_in    = ptr_ff + AW'(1);
            cursor_in = last;
            col_in    = '0;
         end
         tcw_pkg::DP_VIEW: begin
            if ({1'b0, cursor_ff} >= view_end) begin
               view_in = view_ff + AW'(tcw_pkg::COLUMNS);
            end else if (cursor_ff < view_ff) begin
               if (view_ff <= AW'(tcw_pkg::COLUMNS)) begin
                  view_in   = '0;
                  cursor_in = '0;
                  col_in    = '0;
               end else begin
                  view_in = view_ff - AW'(tcw_pkg::COLUMNS);
               end
            end
         end
         tcw_pkg::DP_RESPOND: begin
            rsp_valid_in      = 1'b1;
            rsp_in.cursor_pos = cursor_ff;
            rsp_in.view_start = view_ff;
            if (status.is_read && idx_ok) begin
               rsp_in.cell_char = mem_rdata[tcw_pkg::CHAR_W-1:0];
               rsp_in.cell_attr = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end else begin
               rsp_in.cell_char = '0;
               rsp_in.cell_attr = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         view_ff      <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         steps_ff     <= '0;
         attr_ff      <= tcw_pkg::RESET_ATTR;
         region_ff    <= tcw_pkg::RESET_LINES;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         view_ff      <= view_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         steps_ff     <= steps_in;
         attr_ff      <= attr_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      rsp_ff     <= rsp_in;
      item_ff    <= item_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/tcw_ctrl.sv]
// Controller: sequences the clearing pass, each put or read beat, scrolling and the result.
module tcw_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tcw_pkg::dp_status_type       status,
   output tcw_pkg::dp_op_type           cmd
);

   typedef enum logic [12:0] {
      S_CLEAR       = 13'b0000000000001,
      S_IDLE        = 13'b0000000000010,
      S_DECODE      = 13'b0000000000100,
      S_PRINT       = 13'b0000000001000,
      S_NL_FILL     = 13'b0000000010000,
      S_BS_READ     = 13'b0000000100000,
      S_BS_CHECK    = 13'b0000001000000,
      S_BS_SPACE    = 13'b0000010000000,
      S_SCROLL_CHK  = 13'b0000100000000,
      S_SCROLL_COPY = 13'b0001000000000,
      S_SCROLL_ZERO = 13'b0010000000000,
      S_VIEW        = 13'b0100000000000,
      S_FINISH      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = tcw_pkg::DP_NOP;
      req_ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cmd = tcw_pkg::DP_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = tcw_pkg::DP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (status.is_read) begin
               state_in = S_FINISH;
            end else if (status.is_nl) begin
               state_in = S_NL_FILL;
            end else if (status.is_bs) begin
               state_in = status.cur_zero ? S_SCROLL_CHK : S_BS_READ;
            end else begin
               state_in = S_PRINT;
            end
         end
         S_PRINT: begin
            cmd      = tcw_pkg::DP_PRINT;
            state_in = S_SCROLL_CHK;
         end
         S_NL_FILL: begin
            cmd = tcw_pkg::DP_NL_FILL;
            if (status.nl_last) begin
               state_in = S_SCROLL_CHK;
            end
         end
         S_BS_READ: begin
            cmd      = tcw_pkg::DP_BS_READ;
            state_in = S_BS_CHECK;
         end
         S_BS_CHECK: begin
            if (status.bs_blank) begin
               cmd      = tcw_pkg::DP_BS_STEP;
               state_in = status.bs_stop ? S_SCROLL_CHK : S_BS_READ;
            end else begin
               state_in = status.bs_moved ? S_SCROLL_CHK : S_BS_SPACE;
            end
         end
         S_BS_SPACE: begin
            cmd      = tcw_pkg::DP_BS_SPACE;
            state_in = S_SCROLL_CHK;
         end
         S_SCROLL_CHK: begin
            if (status.scroll_need) begin
               cmd      = tcw_pkg::DP_SCROLL_START;
               state_in = S_SCROLL_COPY;
            end else begin
               state_in = S_VIEW;
            end
         end
         S_SCROLL_COPY: begin
            if (status.copy_done) begin
               state_in = S_SCROLL_ZERO;
            end else begin
               cmd = tcw_pkg::DP_SCROLL_COPY;
            end
         end
         S_SCROLL_ZERO: begin
            cmd = tcw_pkg::DP_SCROLL_ZERO;
            if (status.zero_last) begin
               state_in = S_VIEW;
            end
         end
         S_VIEW: begin
            cmd      = tcw_pkg::DP_VIEW;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the result register is free
            if (status.rsp_free) begin
               cmd      = tcw_pkg::DP_RESPOND;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/text_console_writer_unit.sv]
// Text console writer top level: request/result channels and configuration port.
//
// An 80-column console over a 5120-cell store of (character, attribute) pairs at cell 0.
// After reset a clearing pass writes zero to every cell, one a cycle; no request is taken
// until it ends, though configuration writes are. Requests are then handled one at a time,
// with the cell store's single write and single registered read port setting the pace: a
// newline fills the rest of its line with blank cells (up to 80), a backspace steps back over
// up to 80 blank cells or else writes a space over the cell before the cursor. A put that runs
// past the end of the region also scrolls: every cell of the region is walked once. A result
// still waiting in the output register holds the block in its last cycle until it is taken,
// but does not stop the next request from being taken.
module text_console_writer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tcw_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tcw_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [tcw_pkg::CSR_W-1:0] csr_wdata
);

   tcw_pkg::dp_op_type     cmd;
   tcw_pkg::dp_status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the text console writer: directed table, then random traffic.
module tb;

   localparam int unsigned QUIET_LIMIT  = 40000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned AW           = tcw_pkg::ADDR_W;

   typedef enum logic [1:0] {
      STEP_PUT,
      STEP_READ,
      STEP_ATTR,
      STEP_LINES
   } step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [AW-1:0]     arg;
      logic              pinned;
      tcw_pkg::rsp_type  want;
   } script_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   tcw_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   tcw_pkg::rsp_type          rsp_data;
   logic                      csr_we;
   logic [0:0]                csr_index;
   logic [tcw_pkg::CSR_W-1:0] csr_wdata;

   // expectation pinned to the beat currently offered
   logic             pin_en;
   tcw_pkg::rsp_type pin_rsp;

   logic [tcw_pkg::CELL_W-1:0]  model_cells [0:tcw_pkg::STORE_CELLS-1];
   int unsigned                 model_cursor;
   int unsigned                 model_view;
   logic [tcw_pkg::ATTR_W-1:0]  model_attr;
   logic [tcw_pkg::LINES_W-1:0] model_lines;

   tcw_pkg::rsp_type console_due[$];
   script_row_type   script[$];
   int unsigned      mismatches;
   int unsigned      quiet_cycles;
   int unsigned      send_idle_pct;
   int unsigned      recv_idle_pct;
   int unsigned      hold_asks;

   text_console_writer_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned region_cells(logic [tcw_pkg::LINES_W-1:0] lines);
      int unsigned n;
      n = 32'(lines);
      if (n > tcw_pkg::MAX_LINES) n = tcw_pkg::MAX_LINES;
      if (n == 0) n = 1;
      return n * tcw_pkg::COLUMNS;
   endfunction

   function automatic logic [tcw_pkg::CELL_W-1:0] fetch_cell(int unsigned idx);
      return (idx < tcw_pkg::STORE_CELLS) ? model_cells[idx] : '0;
   endfunction

   function automatic void store_cell(int unsigned idx, logic [tcw_pkg::CELL_W-1:0] v);
      if (idx < tcw_pkg::STORE_CELLS) model_cells[idx] = v;
   endfunction

   function automatic tcw_pkg::rsp_type console_step(tcw_pkg::req_type r);
      tcw_pkg::rsp_type           o;
      int unsigned                cur, view, limit, fill, last, k;
      logic                       moved;
      logic [tcw_pkg::CELL_W-1:0] cell_word;
      cur  = model_cursor;
      view = model_view;
      o    = '0;
      if (r.opcode == tcw_pkg::OP_READ) begin
         cell_word    = fetch_cell(32'(r.cell_index));
         o.cursor_pos = cur[AW-1:0];
         o.view_start = view[AW-1:0];
         o.cell_char  = cell_word[tcw_pkg::CHAR_W-1:0];
         o.cell_attr  = cell_word[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
         return o;
      end
      limit = region_cells(model_lines);
      if (r.char_code == tcw_pkg::CH_LF || r.char_code == tcw_pkg::CH_CR) begin
         fill = tcw_pkg::COLUMNS - cur % tcw_pkg::COLUMNS;
         for (k = 0; k < fill; k++) store_cell(cur + k, tcw_pkg::BLANK_CELL);
         cur += fill;
      end else if (r.char_code == tcw_pkg::CH_BS) begin
         if (cur > 0) begin
            moved = 1'b0;
            for (k = 0; k < tcw_pkg::COLUMNS && cur > 0 &&
                        fetch_cell(cur - 1) == tcw_pkg::BLANK_CELL; k++) begin
               cur--;
               moved = 1'b1;
            end
            if (!moved) begin
               store_cell(cur - 1, tcw_pkg::SPACE_CELL);
               cur--;
            end
         end
      end else begin
         store_cell(cur, {model_attr, r.char_code});
         cur++;
      end
      // scroll the region up one line
      if (cur >= limit) begin
         last = limit - tcw_pkg::COLUMNS;
         for (k = 0; k < last; k++) store_cell(k, fetch_cell(k + tcw_pkg::COLUMNS));
         for (k = last; k < limit; k++) store_cell(k, '0);
         cur = last;
      end
      if (cur >= view + tcw_pkg::SCREEN_ROWS * tcw_pkg::COLUMNS) begin
         view += tcw_pkg::COLUMNS;
      end else if (cur < view) begin
         if (view <= tcw_pkg::COLUMNS) begin
            view = 0;
            cur  = 0;
         end else begin
            view -= tcw_pkg::COLUMNS;
         end
      end
      model_cursor = cur & 32'h1FFF;
      model_view   = view & 32'h1FFF;
      o.cursor_pos = model_cursor[AW-1:0];
      o.view_start = model_view[AW-1:0];
      return o;
   endfunction

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : track
      tcw_pkg::rsp_type guess;
      tcw_pkg::rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == tcw_pkg::CSR_TEXT_ATTR) model_attr = csr_wdata;
            else model_lines = csr_wdata[tcw_pkg::LINES_W-1:0];
         end
         if (req_valid && req_ready) begin
            guess = console_step(req_data);
            console_due.push_back(pin_en ? pin_rsp : guess);
         end
         if (rsp_valid && rsp_ready) begin
            if (console_due.size() == 0) begin
               $display("%0t: result with nothing due, expected none got %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = console_due.pop_front();
               check_field("cursor_pos", 32'(want.cursor_pos), 32'(rsp_data.cursor_pos));
               check_field("view_start", 32'(want.view_start), 32'(rsp_data.view_start));
               check_field("cell_char", 32'(want.cell_char), 32'(rsp_data.cell_char));
               check_field("cell_attr", 32'(want.cell_attr), 32'(rsp_data.cell_attr));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : rx_side
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         // a fresh request starts a long hold-off
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
         @(negedge clock);
      end
   end

   function automatic script_row_type row(step_kind_type k, int unsigned a, logic p,
                                          int unsigned cp, int unsigned vs, int unsigned ch,
                                          int unsigned at);
      script_row_type r;
      r.kind            = k;
      r.arg             = a[AW-1:0];
      r.pinned          = p;
      r.want.cursor_pos = cp[AW-1:0];
      r.want.view_start = vs[AW-1:0];
      r.want.cell_char  = ch[tcw_pkg::CHAR_W-1:0];
      r.want.cell_attr  = at[tcw_pkg::ATTR_W-1:0];
      return r;
   endfunction

   // offer one beat; return at the falling edge after it is taken
   task automatic send_item(tcw_pkg::req_type r, logic pinned, tcw_pkg::rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      pin_en    <= pinned;
      pin_rsp   <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (console_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(tcw_pkg::csr_reg_type idx, logic [tcw_pkg::CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(logic [tcw_pkg::CSR_W-1:0] attr, logic [tcw_pkg::CSR_W-1:0] lines,
                            int unsigned send_pct, int unsigned recv_pct,
                            logic squeeze, int unsigned count);
      int unsigned      sent, pick, cells, k;
      int               run;
      tcw_pkg::req_type beat;
      settle();
      write_csr(tcw_pkg::CSR_TEXT_ATTR, attr);
      write_csr(tcw_pkg::CSR_REGION_LINES, lines);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (squeeze) hold_asks++;
      sent = 0;
      while (sent < count) begin
         cells            = region_cells(model_lines);
         pick             = $urandom_range(0, 99);
         run              = 1;
         beat.opcode      = tcw_pkg::OP_PUT;
         beat.char_code   = 8'($urandom_range(0, 255));
         beat.cell_index  = AW'($urandom_range(0, 8191));
         if (pick < 40) begin
            // printable or any other byte, as drawn
         end else if (pick < 58) begin
            beat.char_code = $urandom_range(0, 1) ? tcw_pkg::CH_LF : tcw_pkg::CH_CR;
            // hold back line ends on the last line of a big region: each one scrolls
            if (model_cursor + tcw_pkg::COLUMNS >= cells && cells > 8 * tcw_pkg::COLUMNS
                && $urandom_range(0, 5) != 0)
               beat.opcode = tcw_pkg::OP_READ;
         end else if (pick < 70) begin
            beat.char_code = tcw_pkg::CH_BS;
         end else if (pick < 88) begin
            beat.opcode = tcw_pkg::OP_READ;
            if ($urandom_range(0, 1) && model_cursor != 0)
               beat.cell_index = AW'(model_cursor - 1);
         end else if (pick < 94) begin
            // run of line ends down to the last line, sometimes one more to scroll
            beat.char_code = tcw_pkg::CH_LF;
            run = int'(cells / tcw_pkg::COLUMNS) - int'(model_cursor / tcw_pkg::COLUMNS) - 1
                  + int'($urandom_range(0, 1));
            if (run < 1) run = 1;
         end else begin
            beat.char_code = tcw_pkg::CH_BS;
            run = int'($urandom_range(5, 40));
         end
         for (k = 0; k < run; k++) begin
            send_item(beat, 1'b0, '0);
            beat.cell_index = AW'($urandom_range(0, 8191));
         end
         sent += run;
      end
   endtask

   initial begin : main
      tcw_pkg::req_type beat;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      pin_en        = 1'b0;
      pin_rsp       = '0;
      mismatches    = 0;
      quiet_cycles  = 0;
      hold_asks     = 0;
      send_idle_pct = 14;
      recv_idle_pct = 58;
      for (int i = 0; i < tcw_pkg::STORE_CELLS; i++) model_cells[i] = '0;
      model_cursor = 0;
      model_view   = 0;
      model_attr   = tcw_pkg::RESET_ATTR;
      model_lines  = tcw_pkg::RESET_LINES;

      script.push_back(row(STEP_READ, 0, 1'b1, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 8191, 1'b1, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 5119, 1'b1, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_BS), 1'b1, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 'h41, 1'b1, 1, 0, 0, 0));
      script.push_back(row(STEP_READ, 0, 1'b1, 1, 0, 'h41, 7));
      script.push_back(row(STEP_PUT, 'hFF, 1'b1, 2, 0, 0, 0));
      script.push_back(row(STEP_PUT, 0, 1'b1, 3, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_BS), 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_BS), 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 1, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_LF), 1'b1, 80, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_CR), 1'b1, 160, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_BS), 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_BS), 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_ATTR, 'hFF, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 'h7A, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 1, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_ATTR, 0, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 'h7E, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 2, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_LINES, 0, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_LF), 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_READ, 0, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_LINES, 'h7F, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_PUT, 32'(tcw_pkg::CH_CR), 1'b0, 0, 0, 0, 0));
      // top bit of the write is dropped: back to the full region
      script.push_back(row(STEP_LINES, 'hC0, 1'b0, 0, 0, 0, 0));
      script.push_back(row(STEP_ATTR, 7, 1'b0, 0, 0, 0, 0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[n]) begin
         case (script[n].kind)
            STEP_ATTR: begin
               settle();
               write_csr(tcw_pkg::CSR_TEXT_ATTR, script[n].arg[tcw_pkg::CSR_W-1:0]);
            end
            STEP_LINES: begin
               settle();
               write_csr(tcw_pkg::CSR_REGION_LINES, script[n].arg[tcw_pkg::CSR_W-1:0]);
            end
            default: begin
               beat = '0;
               if (script[n].kind == STEP_READ) begin
                  beat.opcode     = tcw_pkg::OP_READ;
                  beat.cell_index = script[n].arg;
               end else begin
                  beat.opcode    = tcw_pkg::OP_PUT;
                  beat.char_code = script[n].arg[tcw_pkg::CHAR_W-1:0];
               end
               send_item(beat, script[n].pinned, script[n].want);
            end
         endcase
      end

      run_phase(8'($urandom_range(0, 255)), 8'd26, 14, 58, 1'b0, 230);
      run_phase(8'h00, 8'd0, 14, 58, 1'b1, 180);
      run_phase(8'hFF, 8'd64, 58, 14, 1'b0, 230);
      run_phase(8'($urandom_range(0, 255)), 8'd3, 58, 14, 1'b0, 200);
      run_phase(8'($urandom_range(0, 255)), 8'd127, 0, 0, 1'b0, 200);
      run_phase(8'($urandom_range(0, 255)), 8'd25, 0, 0, 1'b0, 220);
      run_phase(8'($urandom_range(0, 255)), 8'd40, 0, 0, 1'b0, 170);

      settle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[text_console_writer_unit.f]
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/tcw_datapath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_unit.sv
tb/sv/tb.sv
